>>> design/tlpq_pkg.sv
// Package for the two-level priority queue: payload structs, codes and constants.
// No dependencies; imported by tlpq_ctrl, two_level_priority_queue_top and the testbench.
`default_nettype none

package tlpq_pkg;

    // Item kinds
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_PRIO = 2'd1;
    localparam logic [1:0] KIND_DEQ  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Configuration port: byte address width and register word index
    localparam int unsigned APB_AW        = 3;
    localparam logic        REG_THRESHOLD = 1'b0;

    localparam logic signed [31:0] THR_RESET = 32'sd60;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [4:0]         occupancy;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SCAN,
        ST_PLACE,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

>>> design/tlpq_slot_ram.sv
// Slot storage of the queue: one write port, one read port, registered read data.
// Depends on nothing; instantiated by two_level_priority_queue_top.
`default_nettype none

module tlpq_slot_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [AW-1:0]            i_waddr,
    input  wire  signed [31:0]       i_wdata,
    input  wire                      i_re,
    input  wire  [AW-1:0]            i_raddr,
    output logic signed [31:0]       o_rdata
);

    logic signed [31:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/tlpq_ctrl.sv
// Queue sequencer: circular head pointer and count, scan-and-shift for priority inserts.
// Depends on tlpq_pkg; drives the ports of tlpq_slot_ram.
`default_nettype none

module tlpq_ctrl
    import tlpq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4,
    parameter int unsigned CW    = 5
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    input  wire  signed [31:0]   i_thr,
    output logic                 o_res_valid,
    input  wire                  i_res_take,
    output t_out_item            o_res,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic signed [31:0]   o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    input  wire  signed [31:0]   i_rdata
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_prev, n_prev;
    logic [AW-1:0]      r_cur, n_cur;
    logic [CW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    t_out_item          r_res, n_res;

    logic [AW-1:0] head_inc, head_dec, cur_inc, tail;
    logic [AW:0]   tail_sum;
    logic [CW-1:0] cnt_inc, cnt_dec;
    logic          full, empty, in_high, rd_high, last;

    // Pointer arithmetic, wrapping at DEPTH
    always_comb begin
        head_inc = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
        head_dec = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
        cur_inc  = (r_cur == LAST_SLOT) ? '0 : r_cur + AW'(1);
        tail_sum = (AW+1)'(r_head) + (AW+1)'(r_count);
        tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                : AW'(tail_sum);
        cnt_inc  = r_count + CW'(1);
        cnt_dec  = r_count - CW'(1);
        full     = (r_count == FULL_CNT);
        empty    = (r_count == '0);
        in_high  = (i_in.value >= i_thr);
        rd_high  = (i_rdata >= i_thr);
        last     = ((r_idx + CW'(1)) == r_count);
    end

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_res  <= n_res;
    end

    // Next state, memory accesses and result
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_val   = r_val;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_prev;
        o_wdata = r_val;
        o_re    = 1'b0;
        o_raddr = r_cur;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_val             = i_in.value;
                    n_res.status      = STAT_OK;
                    n_res.removed_value = '0;
                    n_res.occupancy   = 5'(r_count);
                    n_state           = ST_RESP;
                    if (i_in.kind == KIND_ENQ || i_in.kind == KIND_PRIO) begin
                        if (full) begin
                            n_res.status = STAT_FULL;
                        end else if (i_in.kind == KIND_PRIO && in_high) begin
                            if (empty) begin
                                // sole entry: grow at the head
                                o_we            = 1'b1;
                                o_waddr         = head_dec;
                                o_wdata         = i_in.value;
                                n_head          = head_dec;
                                n_count         = cnt_inc;
                                n_res.occupancy = 5'(cnt_inc);
                            end else begin
                                // start scanning the leading high run
                                o_re    = 1'b1;
                                o_raddr = r_head;
                                n_prev  = head_dec;
                                n_cur   = r_head;
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end else begin
                            // append at the tail
                            o_we            = 1'b1;
                            o_waddr         = tail;
                            o_wdata         = i_in.value;
                            n_count         = cnt_inc;
                            n_res.occupancy = 5'(cnt_inc);
                        end
                    end else if (i_in.kind == KIND_DEQ) begin
                        if (empty) begin
                            n_res.status = STAT_EMPTY;
                        end else begin
                            o_re    = 1'b1;
                            o_raddr = r_head;
                            n_state = ST_DEQ;
                        end
                    end
                end
            end
            ST_DEQ: begin
                // head data is back: pop it
                n_res.removed_value = i_rdata;
                n_head              = head_inc;
                n_count             = cnt_dec;
                n_res.occupancy     = 5'(cnt_dec);
                n_state             = ST_RESP;
            end
            ST_SCAN: begin
                o_we    = 1'b1;
                o_waddr = r_prev;
                if (rd_high) begin
                    // move this high entry one slot toward the head
                    o_wdata = i_rdata;
                    n_prev  = r_cur;
                    if (last) begin
                        n_state = ST_PLACE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = cur_inc;
                        n_cur   = cur_inc;
                        n_idx   = r_idx + CW'(1);
                    end
                end else begin
                    // first low entry: new value goes just before it
                    o_wdata         = r_val;
                    n_head          = head_dec;
                    n_count         = cnt_inc;
                    n_res.occupancy = 5'(cnt_inc);
                    n_state         = ST_RESP;
                end
            end
            ST_PLACE: begin
                // whole queue was high: new value goes last
                o_we            = 1'b1;
                o_waddr         = r_prev;
                o_wdata         = r_val;
                n_head          = head_dec;
                n_count         = cnt_inc;
                n_res.occupancy = 5'(cnt_inc);
                n_state         = ST_RESP;
            end
            ST_RESP: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_RESP);
    assign o_res       = r_res;

endmodule

`default_nettype wire

>>> design/two_level_priority_queue_top.sv
// Top level of the two-level priority queue: threshold register, output register, assertions.
// Depends on tlpq_pkg, tlpq_slot_ram and tlpq_ctrl.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | i_in_valid, o_in_stall, i_in (t_in_item)  | in
//  output    | o_out_valid, i_out_stall, o_out           | out
//  config    | psel, penable, pwrite, paddr, pwdata,     | APB
//            | prdata, pready                            |
//
// One item at a time. A priority enqueue of a high value into a non-empty queue that is not
// full scans the leading high run, reading one slot per cycle; other items do not scan.
// Reset (synchronous, active low) empties the queue and sets the threshold to 60;
// slot contents are not cleared. A stalled result stays in the output register
// while the next item is accepted and worked on.
`default_nettype none

module two_level_priority_queue_top
    import tlpq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output t_out_item           o_out,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic signed [31:0] r_thr;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               res_valid, res_take;
    t_out_item          res;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic signed [31:0] ram_wdata, ram_rdata;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_THRESHOLD) begin
            r_thr <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_THRESHOLD) ? r_thr : '0;

    tlpq_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tlpq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_thr       (r_thr),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    // Output register: load when empty or when its transfer completes
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // A rejected enqueue reports a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == STAT_FULL) |-> (o_out.occupancy == 5'(QUEUE_DEPTH)))
        else $error("full status with wrong occupancy");

    // A failed dequeue reports an empty queue
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == STAT_EMPTY) |-> (o_out.occupancy == 5'd0))
        else $error("empty status with nonzero occupancy");

    // Only a successful dequeue carries a removed value
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != STAT_OK) |-> (o_out.removed_value == 32'sd0))
        else $error("removed value on a failed item");

    // An accepted item stalls the input in the cycle after its transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after a transfer");
`endif

endmodule

`default_nettype wire

>>> test/tb_two_level_priority_queue_top.sv
// Self-checking testbench for two_level_priority_queue_top: a mirror queue predicts every
// result, random gaps and stalls load both channels. Depends on tlpq_pkg and the design.
`default_nettype none

// Mirror of the queue: predicts one result per accepted item and checks results in order
class order_queue_board;
    logic signed [31:0]    mirror_slots [16];
    int unsigned           mirror_count;
    logic signed [31:0]    mirror_thr;
    tlpq_pkg::t_out_item   pending_results [$];
    int unsigned           failures;

    function new();
        mirror_count = 0;
        mirror_thr   = tlpq_pkg::THR_RESET;
        failures     = 0;
        foreach (mirror_slots[i]) mirror_slots[i] = '0;
    endfunction

    function void set_threshold(input logic signed [31:0] thr);
        mirror_thr = thr;
    endfunction

    function int unsigned pending();
        return pending_results.size();
    endfunction

    // Shift the tail up by one and place the value at pos
    function void insert_value(input int unsigned pos, input logic signed [31:0] v);
        for (int unsigned i = mirror_count; i > pos; i--) mirror_slots[i] = mirror_slots[i - 1];
        mirror_slots[pos] = v;
        mirror_count++;
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_item(input tlpq_pkg::t_in_item item);
        tlpq_pkg::t_out_item res;
        int unsigned         pos;
        logic signed [31:0]  v;
        v                 = $signed(item.value);
        res.status        = tlpq_pkg::STAT_OK;
        res.removed_value = '0;
        if (item.kind == tlpq_pkg::KIND_ENQ || item.kind == tlpq_pkg::KIND_PRIO) begin
            if (mirror_count >= 16) begin
                res.status = tlpq_pkg::STAT_FULL;
            end else if (item.kind == tlpq_pkg::KIND_PRIO && v >= mirror_thr) begin
                // skip the leading run of high values
                pos = 0;
                while (pos < mirror_count && mirror_slots[pos] >= mirror_thr) pos++;
                insert_value(pos, v);
            end else begin
                insert_value(mirror_count, v);
            end
        end else if (item.kind == tlpq_pkg::KIND_DEQ) begin
            if (mirror_count == 0) begin
                res.status = tlpq_pkg::STAT_EMPTY;
            end else begin
                res.removed_value = mirror_slots[0];
                for (int unsigned i = 1; i < mirror_count; i++)
                    mirror_slots[i - 1] = mirror_slots[i];
                mirror_count--;
            end
        end
        res.occupancy = mirror_count[4:0];
        pending_results.push_back(res);
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(input tlpq_pkg::t_out_item got);
        tlpq_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d removed_value %0d occupancy %0d",
                   got.status, got.removed_value, got.occupancy);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
        end
        if (got.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, actual %0d",
                   want.removed_value, got.removed_value);
            failures++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
            failures++;
        end
    endfunction
endclass

module tb_two_level_priority_queue_top;
    import tlpq_pkg::*;

    localparam logic [1:0]        KIND_UNUSED    = 2'd3;
    localparam logic [APB_AW-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
    localparam int unsigned       DRAIN_CYCLES   = 24;
    localparam int unsigned       LONG_HOLD      = 400;
    localparam int unsigned       CYCLE_LIMIT    = 800000;
    localparam int unsigned       PHASE_ITEMS    = 170;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    order_queue_board    board;
    bit                  calm         = 1'b0;
    bit                  hold_request = 1'b0;
    int unsigned         cycle_count  = 0;

    two_level_priority_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL two_level_priority_queue_top");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) board.check_result(o_out);
    end

    // Result side: random stall, one long hold on request, none while calm
    initial begin : result_side
        int unsigned r;
        int unsigned n;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(1, 6);
                end else if (r < 92) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(10, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic offer_item(input logic [1:0] kind, input logic signed [31:0] value);
        t_in_item item;
        item.kind  = kind;
        item.value = value;
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(item);
    endtask

    // Idle the input for a random gap, mostly short
    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(99);
        if (calm || r < 55) n = 0;
        else if (r < 90)    n = $urandom_range(1, 3);
        else                n = $urandom_range(10, 40);
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [1:0] kind, input logic signed [31:0] value);
        offer_item(kind, value);
        sender_gap();
    endtask

    // Drop valid, wait for every predicted result, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the threshold register: setup phase, then access phase
    task automatic write_threshold(input logic signed [31:0] thr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= thr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_threshold(thr);
        @(posedge i_clk);
    endtask

    // Values clustered around the threshold, plus extremes and noise
    function automatic logic signed [31:0] pick_value(input logic signed [31:0] thr);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)      return thr + 32'($urandom_range(8)) - 32'd4;
        else if (r < 50) return thr;
        else if (r < 70) return $urandom();
        else if (r < 85) return 32'($urandom_range(256)) - 32'd128;
        else if (r < 92) return 32'h7FFF_FFFF;
        else             return 32'h8000_0000;
    endfunction

    // Random items in bursts that lean toward filling, balancing or draining
    task automatic run_phase(input int unsigned n_items, input int hold_at);
        int unsigned done;
        int unsigned burst;
        int unsigned enq_pct;
        int unsigned r;
        logic [1:0]  kind;
        done = 0;
        while (done < n_items) begin
            r       = $urandom_range(2);
            enq_pct = (r == 0) ? 85 : (r == 1) ? 50 : 15;
            burst   = $urandom_range(8, 40);
            repeat (burst) begin
                if ($urandom_range(99) < 3)            kind = KIND_UNUSED;
                else if ($urandom_range(99) < enq_pct) kind = $urandom_range(1) ? KIND_PRIO
                                                                                : KIND_ENQ;
                else                                   kind = KIND_DEQ;
                send(kind, pick_value(board.mirror_thr));
                done++;
                if (done == hold_at) hold_request = 1'b1;
            end
        end
    endtask

    initial begin : stimulus
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, unused kind, priority placement, full queue
        send(KIND_DEQ,    32'sd0);
        send(KIND_UNUSED, -32'sd1);
        send(KIND_PRIO,   32'sd60);
        send(KIND_DEQ,    32'sd5);
        send(KIND_PRIO,   32'sd59);
        send(KIND_PRIO,   32'sd60);
        send(KIND_PRIO,   32'h7FFF_FFFF);
        send(KIND_ENQ,    32'sd100);
        send(KIND_PRIO,   32'h8000_0000);
        send(KIND_ENQ,    32'sd0);
        send(KIND_DEQ,    32'h5555_5555);
        for (int i = 0; i < 11; i++) send(KIND_ENQ, (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
        send(KIND_ENQ,    32'sd1);
        send(KIND_PRIO,   32'h7FFF_FFFF);
        send(KIND_DEQ,    32'sd0);
        send(KIND_UNUSED, 32'h7FFF_FFFF);
        wait_drained();

        // Random phases over several thresholds, extremes included
        run_phase(PHASE_ITEMS, 60);
        wait_drained();
        write_threshold(32'h8000_0000);
        run_phase(PHASE_ITEMS, -1);
        wait_drained();
        write_threshold(32'h7FFF_FFFF);
        run_phase(PHASE_ITEMS, -1);
        wait_drained();
        calm = 1'b1;
        write_threshold(32'sd0);
        run_phase(PHASE_ITEMS, -1);
        wait_drained();
        calm = 1'b0;
        write_threshold(32'sd59);
        run_phase(PHASE_ITEMS, -1);
        wait_drained();
        write_threshold($urandom());
        run_phase(PHASE_ITEMS, -1);
        wait_drained();
        write_threshold(THR_RESET);
        run_phase(PHASE_ITEMS, -1);
        wait_drained();

        if (board.failures == 0) begin
            $display("PASS two_level_priority_queue_top");
        end else begin
            $display("FAIL two_level_priority_queue_top");
        end
        $finish;
    end
endmodule

`default_nettype wire
